// ===== rtl/core/sexpr_char_lexer_defines.svh =====
// Assertion macros for the s-expression lexer.
// Used by the modules in rtl/core; no other dependencies.
`ifndef SEXPR_CHAR_LEXER_DEFINES_SVH
`define SEXPR_CHAR_LEXER_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define SLX_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Overlapping implication checked at every clock edge out of reset.
`define SLX_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked at every clock edge out of reset.
`define SLX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/slx_pkg.sv =====
// Shared types, constants and helpers for the s-expression lexer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slx_pkg;

   localparam int TOKEN_LIMIT = 32;
   localparam int NEST_LIMIT  = 63;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_QMARK  = 8'h3f;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_BAR    = 8'h7c;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_CHARLIT = 3'd2,
      MODE_TOKEN   = 3'd3,
      MODE_TEXT    = 3'd4,
      MODE_ESCAPE  = 3'd5
   } lex_mode_type;

   typedef enum logic [3:0] {
      EV_OPEN     = 4'd0,
      EV_CLOSE    = 4'd1,
      EV_DOT      = 4'd2,
      EV_QUOTE    = 4'd3,
      EV_CHARLIT  = 4'd4,
      EV_TOKCHAR  = 4'd5,
      EV_SYMEND   = 4'd6,
      EV_INTEND   = 4'd7,
      EV_TEXTCHAR = 4'd8,
      EV_STREND   = 4'd9,
      EV_BAREND   = 4'd10
   } event_kind_type;

   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     chr;
      logic [31:0]    value;
      logic [5:0]     len;
      logic           last;
   } event_type;

   // Events from one character, up to two, in order.
   typedef struct packed {
      logic      vld;
      logic [1:0] num;
      event_type  ev0;
      event_type  ev1;
   } push_type;

   function automatic event_type make_event(event_kind_type kind, logic [7:0] chr,
                                            logic [5:0] len);
      event_type e;
      e.kind  = kind;
      e.chr   = chr;
      e.value = 32'd0;
      e.len   = len;
      e.last  = 1'b0;
      return e;
   endfunction

   // End of a plain token: integer when all digits, a lone minus is a symbol.
   function automatic event_type end_event(logic all_dig, logic minus, logic [5:0] cnt,
                                           logic [31:0] acc);
      event_type e;
      e = make_event(EV_SYMEND, 8'd0, cnt);
      if (all_dig && !(minus && cnt == 6'd1)) begin
         e.kind  = EV_INTEND;
         e.value = minus ? (32'd0 - acc) : acc;
      end
      return e;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/slx_core.sv =====
// Lexer state and per-character step logic; emits up to two events per item.
// Depends on slx_pkg and sexpr_char_lexer_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sexpr_char_lexer_defines.svh"

module slx_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       char_in,
   output slx_pkg::push_type     push
);

   slx_pkg::lex_mode_type mode_ff, mode_in;
   logic [5:0]  depth_ff, depth_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        minus_ff, minus_in;
   logic        alldig_ff, alldig_in;
   logic [31:0] acc_ff, acc_in;
   logic        bar_ff, bar_in;

   slx_pkg::event_type ev_c [2];
   logic [1:0]  num_c;
   logic        do_idle, do_tok, do_text;
   logic        dig;
   logic        delim;
   logic [7:0]  closer;

   always_comb begin
      dig   = (char_in >= slx_pkg::CH_ZERO) && (char_in <= slx_pkg::CH_NINE);
      delim = (char_in <= slx_pkg::CH_SPACE) || (char_in == slx_pkg::CH_SEMI)
              || (char_in == slx_pkg::CH_QUOTE) || (char_in == slx_pkg::CH_DQUOTE)
              || (char_in == slx_pkg::CH_LPAREN) || (char_in == slx_pkg::CH_RPAREN);
      closer = bar_ff ? slx_pkg::CH_BAR : slx_pkg::CH_DQUOTE;
   end

   // Next state and raw events, worked through in the order the lexer acts.
   always_comb begin
      mode_in   = mode_ff;
      depth_in  = depth_ff;
      cnt_in    = cnt_ff;
      minus_in  = minus_ff;
      alldig_in = alldig_ff;
      acc_in    = acc_ff;
      bar_in    = bar_ff;
      ev_c[0]   = slx_pkg::make_event(slx_pkg::EV_OPEN, 8'd0, 6'd0);
      ev_c[1]   = slx_pkg::make_event(slx_pkg::EV_OPEN, 8'd0, 6'd0);
      num_c     = 2'd0;
      do_idle   = 1'b0;
      do_tok    = 1'b0;
      do_text   = 1'b0;

      case (mode_ff)
         slx_pkg::MODE_COMMENT: begin
            if (char_in == slx_pkg::CH_CR || char_in == slx_pkg::CH_LF) begin
               mode_in = slx_pkg::MODE_IDLE;
            end
         end
         slx_pkg::MODE_CHARLIT: begin
            mode_in = slx_pkg::MODE_IDLE;
            ev_c[num_c[0]] = slx_pkg::make_event(slx_pkg::EV_CHARLIT, char_in, 6'd0);
            num_c = num_c + 2'd1;
         end
         slx_pkg::MODE_TOKEN: begin
            if (delim) begin
               mode_in = slx_pkg::MODE_IDLE;
               ev_c[num_c[0]] = slx_pkg::end_event(alldig_ff, minus_ff, cnt_ff, acc_ff);
               num_c = num_c + 2'd1;
               do_idle = 1'b1;
            end else begin
               do_tok = 1'b1;
            end
         end
         slx_pkg::MODE_TEXT: begin
            if (char_in == closer) begin
               mode_in = slx_pkg::MODE_IDLE;
               ev_c[num_c[0]] = slx_pkg::make_event(
                  bar_ff ? slx_pkg::EV_BAREND : slx_pkg::EV_STREND, 8'd0, cnt_ff);
               num_c = num_c + 2'd1;
            end else if (char_in == slx_pkg::CH_BSLASH) begin
               mode_in = slx_pkg::MODE_ESCAPE;
            end else begin
               do_text = 1'b1;
            end
         end
         slx_pkg::MODE_ESCAPE: begin
            do_text = 1'b1;
         end
         default: begin
            do_idle = 1'b1;
         end
      endcase

      if (do_idle) begin
         mode_in = slx_pkg::MODE_IDLE;
         if (char_in > slx_pkg::CH_SPACE) begin
            case (char_in)
               slx_pkg::CH_SEMI: begin
                  mode_in = slx_pkg::MODE_COMMENT;
               end
               slx_pkg::CH_QUOTE: begin
                  ev_c[num_c[0]] = slx_pkg::make_event(slx_pkg::EV_QUOTE, 8'd0, 6'd0);
                  num_c = num_c + 2'd1;
               end
               slx_pkg::CH_QMARK: begin
                  mode_in = slx_pkg::MODE_CHARLIT;
               end
               slx_pkg::CH_DQUOTE, slx_pkg::CH_BAR: begin
                  bar_in  = (char_in == slx_pkg::CH_BAR);
                  cnt_in  = 6'd0;
                  mode_in = slx_pkg::MODE_TEXT;
               end
               slx_pkg::CH_LPAREN: begin
                  if (depth_ff < 6'(slx_pkg::NEST_LIMIT)) begin
                     depth_in = depth_ff + 6'd1;
                  end
                  ev_c[num_c[0]] = slx_pkg::make_event(slx_pkg::EV_OPEN, 8'd0, 6'd0);
                  num_c = num_c + 2'd1;
               end
               slx_pkg::CH_RPAREN: begin
                  if (depth_ff != 6'd0) begin
                     depth_in = depth_ff - 6'd1;
                     ev_c[num_c[0]] = slx_pkg::make_event(slx_pkg::EV_CLOSE, 8'd0, 6'd0);
                     num_c = num_c + 2'd1;
                  end else begin
                     cnt_in = 6'd0;
                     do_tok = 1'b1;
                  end
               end
               slx_pkg::CH_DOT: begin
                  if (depth_ff != 6'd0) begin
                     ev_c[num_c[0]] = slx_pkg::make_event(slx_pkg::EV_DOT, 8'd0, 6'd0);
                     num_c = num_c + 2'd1;
                  end else begin
                     cnt_in = 6'd0;
                     do_tok = 1'b1;
                  end
               end
               default: begin
                  cnt_in = 6'd0;
                  do_tok = 1'b1;
               end
            endcase
         end
      end

      if (do_tok) begin
         if (cnt_in == 6'd0) begin
            minus_in  = (char_in == slx_pkg::CH_MINUS);
            alldig_in = minus_in || dig;
            acc_in    = dig ? {28'd0, char_in[3:0]} : 32'd0;
         end else if (dig) begin
            // acc * 10 + digit, wrapping at 32 bits
            acc_in = {acc_in[28:0], 3'b000} + {acc_in[30:0], 1'b0}
                     + {28'd0, char_in[3:0]};
         end else begin
            alldig_in = 1'b0;
         end
         cnt_in  = cnt_in + 6'd1;
         mode_in = slx_pkg::MODE_TOKEN;
         ev_c[num_c[0]] = slx_pkg::make_event(slx_pkg::EV_TOKCHAR, char_in, 6'd0);
         num_c = num_c + 2'd1;
         if (cnt_in >= 6'(slx_pkg::TOKEN_LIMIT)) begin
            mode_in = slx_pkg::MODE_IDLE;
            ev_c[num_c[0]] = slx_pkg::end_event(alldig_in, minus_in, cnt_in, acc_in);
            num_c = num_c + 2'd1;
         end
      end

      if (do_text) begin
         cnt_in  = cnt_in + 6'd1;
         mode_in = slx_pkg::MODE_TEXT;
         ev_c[num_c[0]] = slx_pkg::make_event(slx_pkg::EV_TEXTCHAR, char_in, 6'd0);
         num_c = num_c + 2'd1;
         if (cnt_in >= 6'(slx_pkg::TOKEN_LIMIT)) begin
            mode_in = slx_pkg::MODE_IDLE;
            ev_c[num_c[0]] = slx_pkg::make_event(
               bar_ff ? slx_pkg::EV_BAREND : slx_pkg::EV_STREND, 8'd0, cnt_in);
            num_c = num_c + 2'd1;
         end
      end
   end

   // Output side: mark the final event of the item.
   always_comb begin
      push.vld = step;
      push.num = num_c;
      push.ev0 = ev_c[0];
      push.ev1 = ev_c[1];
      push.ev0.last = (num_c == 2'd1);
      push.ev1.last = (num_c == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= slx_pkg::MODE_IDLE;
         depth_ff  <= 6'd0;
         cnt_ff    <= 6'd0;
         minus_ff  <= 1'b0;
         alldig_ff <= 1'b1;
         acc_ff    <= 32'd0;
         bar_ff    <= 1'b0;
      end else if (step) begin
         mode_ff   <= mode_in;
         depth_ff  <= depth_in;
         cnt_ff    <= cnt_in;
         minus_ff  <= minus_in;
         alldig_ff <= alldig_in;
         acc_ff    <= acc_in;
         bar_ff    <= bar_in;
      end
   end

   `SLX_ASSERT(a_cnt_bound, cnt_ff <= 6'(slx_pkg::TOKEN_LIMIT), "token count past limit")
   `SLX_ASSERT(a_depth_bound, depth_ff <= 6'(slx_pkg::NEST_LIMIT), "nest depth past limit")
   `SLX_ASSERT_IMPL(a_token_nonempty, mode_ff == slx_pkg::MODE_TOKEN, cnt_ff != 6'd0,
                    "token mode with no characters")

endmodule

`default_nettype wire

// ===== rtl/core/slx_rsp_fifo.sv =====
// Result queue: takes up to two events per cycle, hands out one per cycle while rsp_ready is high.
// Depends on slx_pkg and sexpr_char_lexer_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sexpr_char_lexer_defines.svh"

module slx_rsp_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire slx_pkg::push_type push,
   output logic                   room,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [3:0]             rsp_event_kind,
   output logic [7:0]             rsp_char_out,
   output logic signed [31:0]     rsp_int_value,
   output logic [5:0]             rsp_token_len,
   output logic                   rsp_last_of_run
);

   slx_pkg::event_type mem_ff [slx_pkg::RSP_DEPTH];
   logic [slx_pkg::RSP_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [slx_pkg::RSP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0] push_n;
   logic       pop;
   slx_pkg::event_type head;

   assign push_n = push.vld ? push.num : 2'd0;
   assign pop    = rsp_valid && rsp_ready;
   // Room for a full two-event item.
   assign room   = (cnt_ff <= slx_pkg::RSP_CNT_W'(slx_pkg::RSP_DEPTH - 2));

   always_comb begin
      wr_in  = wr_ff + slx_pkg::RSP_PTR_W'(push_n);
      rd_in  = rd_ff + slx_pkg::RSP_PTR_W'(pop);
      cnt_in = cnt_ff + slx_pkg::RSP_CNT_W'(push_n) - slx_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ff] <= push.ev0;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ff + slx_pkg::RSP_PTR_W'(1)] <= push.ev1;
      end
   end

   assign head            = mem_ff[rd_ff];
   assign rsp_valid       = (cnt_ff != '0);
   assign rsp_event_kind  = head.kind;
   assign rsp_char_out    = head.chr;
   assign rsp_int_value   = $signed(head.value);
   assign rsp_token_len   = head.len;
   assign rsp_last_of_run = head.last;

   `SLX_ASSERT(a_fill_bound, cnt_ff <= slx_pkg::RSP_CNT_W'(slx_pkg::RSP_DEPTH),
               "result queue overfilled")
   `SLX_ASSERT_IMPL(a_push_room, push.vld, room, "item pushed without room")
   `SLX_ASSERT_NEXT(a_pop_count, pop && !push.vld,
                    cnt_ff == $past(cnt_ff) - slx_pkg::RSP_CNT_W'(1),
                    "pop did not lower fill")

endmodule

`default_nettype wire

// ===== rtl/core/sexpr_char_lexer.sv =====
// S-expression lexer: one character per item in, token events out.
// Accepted items wait in the input register, then their events enter the result queue.
// Throughput: 1 item per cycle; a two-event item leaves as two separate events, and the
// input stalls while the four-entry result queue holds more than two events.
// Reset (synchronous): input register and queue empty, lexer idle at depth zero.
// Depends on slx_pkg, slx_core and slx_rsp_fifo.
`timescale 1ns / 1ps
`default_nettype none

module sexpr_char_lexer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_char_in,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [3:0]             rsp_event_kind,
   output logic [7:0]             rsp_char_out,
   output logic signed [31:0]     rsp_int_value,
   output logic [5:0]             rsp_token_len,
   output logic                   rsp_last_of_run
);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_char_ff;
   logic       room;
   logic       step;
   slx_pkg::push_type push;

   assign step      = in_vld_ff && room;
   assign req_ready = !in_vld_ff || step;
   assign in_vld_in = (req_valid && req_ready) || (in_vld_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_in;
      end
   end

   slx_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .char_in (in_char_ff),
      .push    (push)
   );

   slx_rsp_fifo u_fifo (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .room            (room),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_char_out    (rsp_char_out),
      .rsp_int_value   (rsp_int_value),
      .rsp_token_len   (rsp_token_len),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Testbench for sexpr_char_lexer: a short table of characters, then random phrases.
// Every accepted character is run through a local lexer model and the events are checked.
// Depends on slx_pkg and the lexer RTL.
`timescale 1ns / 1ps

module testbench;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_char_in = 8'd0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [3:0]         rsp_event_kind;
   logic [7:0]         rsp_char_out;
   logic signed [31:0] rsp_int_value;
   logic [5:0]         rsp_token_len;
   logic               rsp_last_of_run;

   sexpr_char_lexer u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_char_out    (rsp_char_out),
      .rsp_int_value   (rsp_int_value),
      .rsp_token_len   (rsp_token_len),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Directed characters; typed rows carry their single event, others go to the model.
   typedef struct packed {
      logic [7:0]              ch;
      logic                    typed;
      slx_pkg::event_kind_type kind;
      logic [7:0]              chr;
      logic [5:0]              len;
   } script_row_type;

   localparam int SCRIPT_LEN = 29;
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      '{8'h00,              1'b0, slx_pkg::EV_OPEN,     8'h00,              6'd0},
      '{slx_pkg::CH_LPAREN, 1'b1, slx_pkg::EV_OPEN,     8'h00,              6'd0},
      '{slx_pkg::CH_DOT,    1'b1, slx_pkg::EV_DOT,      8'h00,              6'd0},
      '{slx_pkg::CH_RPAREN, 1'b1, slx_pkg::EV_CLOSE,    8'h00,              6'd0},
      '{slx_pkg::CH_RPAREN, 1'b1, slx_pkg::EV_TOKCHAR,  slx_pkg::CH_RPAREN, 6'd0},
      '{slx_pkg::CH_SPACE,  1'b1, slx_pkg::EV_SYMEND,   8'h00,              6'd1},
      '{slx_pkg::CH_QUOTE,  1'b1, slx_pkg::EV_QUOTE,    8'h00,              6'd0},
      '{slx_pkg::CH_QMARK,  1'b0, slx_pkg::EV_OPEN,     8'h00,              6'd0},
      '{8'hff,              1'b1, slx_pkg::EV_CHARLIT,  8'hff,              6'd0},
      '{8'hff,              1'b1, slx_pkg::EV_TOKCHAR,  8'hff,              6'd0},
      '{slx_pkg::CH_LPAREN, 1'b0, slx_pkg::EV_OPEN,     8'h00,              6'd0},
      '{slx_pkg::CH_MINUS,  1'b1, slx_pkg::EV_TOKCHAR,  slx_pkg::CH_MINUS,  6'd0},
      '{slx_pkg::CH_LPAREN, 1'b0, slx_pkg::EV_OPEN,     8'h00,              6'd0},
      '{slx_pkg::CH_MINUS,  1'b0, slx_pkg::EV_OPEN,     8'h00,              6'd0},
      '{"4",                1'b0, slx_pkg::EV_OPEN,     8'h00,              6'd0},
      '{"2",                1'b0, slx_pkg::EV_OPEN,     8'h00,              6'd0},
      '{slx_pkg::CH_RPAREN, 1'b0, slx_pkg::EV_OPEN,     8'h00,              6'd0},
      '{slx_pkg::CH_SEMI,   1'b0, slx_pkg::EV_OPEN,     8'h00,              6'd0},
      '{"x",                1'b0, slx_pkg::EV_OPEN,     8'h00,              6'd0},
      '{slx_pkg::CH_CR,     1'b0, slx_pkg::EV_OPEN,     8'h00,              6'd0},
      '{slx_pkg::CH_DQUOTE, 1'b0, slx_pkg::EV_OPEN,     8'h00,              6'd0},
      '{"a",                1'b1, slx_pkg::EV_TEXTCHAR, "a",                6'd0},
      '{slx_pkg::CH_BSLASH, 1'b0, slx_pkg::EV_OPEN,     8'h00,              6'd0},
      '{slx_pkg::CH_DQUOTE, 1'b1, slx_pkg::EV_TEXTCHAR, slx_pkg::CH_DQUOTE, 6'd0},
      '{slx_pkg::CH_DQUOTE, 1'b1, slx_pkg::EV_STREND,   8'h00,              6'd2},
      '{slx_pkg::CH_BAR,    1'b0, slx_pkg::EV_OPEN,     8'h00,              6'd0},
      '{"b",                1'b0, slx_pkg::EV_OPEN,     8'h00,              6'd0},
      '{slx_pkg::CH_BAR,    1'b1, slx_pkg::EV_BAREND,   8'h00,              6'd1},
      '{slx_pkg::CH_RPAREN, 1'b1, slx_pkg::EV_CLOSE,    8'h00,              6'd0}
   };

   // Lexer model state
   slx_pkg::lex_mode_type lex_mode    = slx_pkg::MODE_IDLE;
   logic [5:0]            nest_depth  = 6'd0;
   logic [5:0]            tok_count   = 6'd0;
   logic                  minus_lead  = 1'b0;
   logic                  only_digits = 1'b1;
   logic [31:0]           tok_value   = 32'd0;
   logic                  bar_text    = 1'b0;

   slx_pkg::event_type    char_events[$];
   slx_pkg::event_type    pending_events[$];
   logic [7:0]            char_feed[$];

   int           error_count   = 0;
   int           send_idle_pct = 0;
   int           rsp_idle_pct  = 0;
   logic         hold_start    = 1'b0;
   logic         hold_rsp      = 1'b0;

   function automatic bit is_digit(logic [7:0] c);
      return c >= slx_pkg::CH_ZERO && c <= slx_pkg::CH_NINE;
   endfunction

   function automatic void add_event(slx_pkg::event_kind_type kind, logic [7:0] chr,
                                     logic [31:0] value, logic [5:0] len);
      slx_pkg::event_type e;
      e.kind  = kind;
      e.chr   = chr;
      e.value = value;
      e.len   = len;
      e.last  = 1'b0;
      char_events.push_back(e);
   endfunction

   function automatic void close_token();
      lex_mode = slx_pkg::MODE_IDLE;
      if (only_digits && !(minus_lead && tok_count == 6'd1))
         add_event(slx_pkg::EV_INTEND, 8'd0,
                   minus_lead ? (32'd0 - tok_value) : tok_value, tok_count);
      else
         add_event(slx_pkg::EV_SYMEND, 8'd0, 32'd0, tok_count);
   endfunction

   function automatic void add_token_char(logic [7:0] c);
      if (tok_count == 6'd0) begin
         minus_lead  = (c == slx_pkg::CH_MINUS);
         only_digits = minus_lead || is_digit(c);
         tok_value   = is_digit(c) ? 32'(c - slx_pkg::CH_ZERO) : 32'd0;
      end else if (is_digit(c)) begin
         tok_value = tok_value * 32'd10 + 32'(c - slx_pkg::CH_ZERO);
      end else begin
         only_digits = 1'b0;
      end
      tok_count = tok_count + 6'd1;
      lex_mode  = slx_pkg::MODE_TOKEN;
      add_event(slx_pkg::EV_TOKCHAR, c, 32'd0, 6'd0);
      if (tok_count >= slx_pkg::TOKEN_LIMIT)
         close_token();
   endfunction

   function automatic void add_text_char(logic [7:0] c);
      tok_count = tok_count + 6'd1;
      lex_mode  = slx_pkg::MODE_TEXT;
      add_event(slx_pkg::EV_TEXTCHAR, c, 32'd0, 6'd0);
      if (tok_count >= slx_pkg::TOKEN_LIMIT) begin
         lex_mode = slx_pkg::MODE_IDLE;
         add_event(bar_text ? slx_pkg::EV_BAREND : slx_pkg::EV_STREND, 8'd0, 32'd0,
                   tok_count);
      end
   endfunction

   function automatic void between_tokens(logic [7:0] c);
      bit plain;
      plain    = 1'b0;
      lex_mode = slx_pkg::MODE_IDLE;
      if (c > slx_pkg::CH_SPACE) begin
         case (c)
            slx_pkg::CH_SEMI:  lex_mode = slx_pkg::MODE_COMMENT;
            slx_pkg::CH_QUOTE: add_event(slx_pkg::EV_QUOTE, 8'd0, 32'd0, 6'd0);
            slx_pkg::CH_QMARK: lex_mode = slx_pkg::MODE_CHARLIT;
            slx_pkg::CH_DQUOTE, slx_pkg::CH_BAR: begin
               bar_text  = (c == slx_pkg::CH_BAR);
               tok_count = 6'd0;
               lex_mode  = slx_pkg::MODE_TEXT;
            end
            slx_pkg::CH_LPAREN: begin
               if (nest_depth < slx_pkg::NEST_LIMIT)
                  nest_depth = nest_depth + 6'd1;
               add_event(slx_pkg::EV_OPEN, 8'd0, 32'd0, 6'd0);
            end
            slx_pkg::CH_RPAREN: begin
               if (nest_depth > 6'd0) begin
                  nest_depth = nest_depth - 6'd1;
                  add_event(slx_pkg::EV_CLOSE, 8'd0, 32'd0, 6'd0);
               end else begin
                  plain = 1'b1;
               end
            end
            slx_pkg::CH_DOT: begin
               if (nest_depth > 6'd0)
                  add_event(slx_pkg::EV_DOT, 8'd0, 32'd0, 6'd0);
               else
                  plain = 1'b1;
            end
            default:   plain = 1'b1;
         endcase
      end
      if (plain) begin
         tok_count = 6'd0;
         add_token_char(c);
      end
   endfunction

   // Events caused by one character land in char_events, last one flagged.
   function automatic void lex_char(logic [7:0] c);
      slx_pkg::event_type e;
      char_events.delete();
      case (lex_mode)
         slx_pkg::MODE_COMMENT: begin
            if (c == slx_pkg::CH_CR || c == slx_pkg::CH_LF)
               lex_mode = slx_pkg::MODE_IDLE;
         end
         slx_pkg::MODE_CHARLIT: begin
            lex_mode = slx_pkg::MODE_IDLE;
            add_event(slx_pkg::EV_CHARLIT, c, 32'd0, 6'd0);
         end
         slx_pkg::MODE_TOKEN: begin
            if (c <= slx_pkg::CH_SPACE || c == slx_pkg::CH_SEMI || c == slx_pkg::CH_QUOTE ||
                c == slx_pkg::CH_DQUOTE || c == slx_pkg::CH_LPAREN ||
                c == slx_pkg::CH_RPAREN) begin
               close_token();
               between_tokens(c);
            end else begin
               add_token_char(c);
            end
         end
         slx_pkg::MODE_TEXT: begin
            if (c == (bar_text ? slx_pkg::CH_BAR : slx_pkg::CH_DQUOTE)) begin
               lex_mode = slx_pkg::MODE_IDLE;
               add_event(bar_text ? slx_pkg::EV_BAREND : slx_pkg::EV_STREND, 8'd0, 32'd0,
                         tok_count);
            end else if (c == slx_pkg::CH_BSLASH) begin
               lex_mode = slx_pkg::MODE_ESCAPE;
            end else begin
               add_text_char(c);
            end
         end
         slx_pkg::MODE_ESCAPE: add_text_char(c);
         default:              between_tokens(c);
      endcase
      if (char_events.size() > 0) begin
         e = char_events.pop_back();
         e.last = 1'b1;
         char_events.push_back(e);
      end
   endfunction

   task automatic send_char(input logic [7:0] c, input bit typed,
                            input slx_pkg::event_type fixed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      lex_char(c);
      if (typed) begin
         fixed.last = 1'b1;
         pending_events.push_back(fixed);
      end else begin
         foreach (char_events[k])
            pending_events.push_back(char_events[k]);
      end
   endtask

   // Mostly well-formed lexemes with random content, some noise.
   task automatic queue_phrase();
      int         pick;
      int         n;
      int         flavor;
      logic [7:0] c;
      logic [7:0] closer;
      pick = $urandom_range(99);
      if (pick < 25) begin
         n      = ($urandom_range(6) == 0) ? $urandom_range(40, 28) : $urandom_range(8, 1);
         flavor = $urandom_range(2);
         if (flavor == 1) begin
            char_feed.push_back(slx_pkg::CH_MINUS);
            n = n - 1;
         end
         for (int k = 0; k < n; k++) begin
            if (flavor < 2) begin
               c = slx_pkg::CH_ZERO + 8'($urandom_range(9));
            end else if (k == 0) begin
               c = "a" + 8'($urandom_range(25));
            end else begin
               do
                  c = 8'($urandom_range(126, 33));
               while (c == slx_pkg::CH_SEMI || c == slx_pkg::CH_QUOTE ||
                      c == slx_pkg::CH_DQUOTE || c == slx_pkg::CH_LPAREN ||
                      c == slx_pkg::CH_RPAREN);
            end
            char_feed.push_back(c);
         end
         case ($urandom_range(4))
            0:       char_feed.push_back(slx_pkg::CH_LPAREN);
            1:       char_feed.push_back(slx_pkg::CH_RPAREN);
            2:       char_feed.push_back(slx_pkg::CH_LF);
            default: char_feed.push_back(slx_pkg::CH_SPACE);
         endcase
      end else if (pick < 40) begin
         closer = $urandom_range(1) ? slx_pkg::CH_BAR : slx_pkg::CH_DQUOTE;
         n      = ($urandom_range(6) == 0) ? $urandom_range(40, 30) : $urandom_range(10);
         char_feed.push_back(closer);
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) begin
               char_feed.push_back(slx_pkg::CH_BSLASH);
               char_feed.push_back(8'($urandom_range(255)));
            end else begin
               do
                  c = 8'($urandom_range(126, 32));
               while (c == closer || c == slx_pkg::CH_BSLASH);
               char_feed.push_back(c);
            end
         end
         char_feed.push_back(closer);
      end else if (pick < 55) begin
         case ($urandom_range(9))
            0, 1, 2, 3: char_feed.push_back(slx_pkg::CH_LPAREN);
            4, 5, 6:    char_feed.push_back(slx_pkg::CH_RPAREN);
            7:          char_feed.push_back(slx_pkg::CH_DOT);
            default:    char_feed.push_back(slx_pkg::CH_QUOTE);
         endcase
      end else if (pick < 58) begin
         // drive nesting past its saturation point and back out
         for (int k = 0; k < 66; k++)
            char_feed.push_back(slx_pkg::CH_LPAREN);
         for (int k = 0; k < 66; k++)
            char_feed.push_back(slx_pkg::CH_RPAREN);
      end else if (pick < 64) begin
         char_feed.push_back(slx_pkg::CH_SEMI);
         n = $urandom_range(10);
         for (int k = 0; k < n; k++) begin
            do
               c = 8'($urandom_range(255));
            while (c == slx_pkg::CH_CR || c == slx_pkg::CH_LF);
            char_feed.push_back(c);
         end
         char_feed.push_back($urandom_range(1) ? slx_pkg::CH_CR : slx_pkg::CH_LF);
      end else if (pick < 71) begin
         char_feed.push_back(slx_pkg::CH_QMARK);
         char_feed.push_back(8'($urandom_range(255)));
      end else if (pick < 85) begin
         n = $urandom_range(3, 1);
         for (int k = 0; k < n; k++)
            char_feed.push_back(8'($urandom_range(32)));
      end else begin
         n = $urandom_range(4, 1);
         for (int k = 0; k < n; k++)
            char_feed.push_back(8'($urandom_range(255)));
      end
   endtask

   always @(posedge clock) begin
      if (reset || hold_rsp)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Long receiver stall so the block backs up into its input
   initial begin
      wait (hold_start);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   always @(posedge clock) begin : event_check
      slx_pkg::event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            error_count++;
            $display("%0t: unexpected event: kind %0d char %h value %0d len %0d last %b",
                     $time, rsp_event_kind, rsp_char_out, rsp_int_value, rsp_token_len,
                     rsp_last_of_run);
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_kind !== want.kind || rsp_char_out !== want.chr ||
                rsp_int_value !== want.value || rsp_token_len !== want.len ||
                rsp_last_of_run !== want.last) begin
               error_count++;
               $display("%0t: event mismatch: expected kind %0d char %h value %0d len %0d last %b",
                        $time, want.kind, want.chr, $signed(want.value), want.len, want.last);
               $display("%0t:                 actual   kind %0d char %h value %0d len %0d last %b",
                        $time, rsp_event_kind, rsp_char_out, rsp_int_value, rsp_token_len,
                        rsp_last_of_run);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   initial begin
      slx_pkg::event_type fixed;
      logic [7:0]         c;
      int                 sent;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         fixed.kind  = SCRIPT[i].kind;
         fixed.chr   = SCRIPT[i].chr;
         fixed.value = 32'd0;
         fixed.len   = SCRIPT[i].len;
         fixed.last  = 1'b1;
         send_char(SCRIPT[i].ch, SCRIPT[i].typed, fixed);
      end

      fixed = '0;
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 24;
               rsp_idle_pct <= 75;
            end
            1: begin
               send_idle_pct = 75;
               rsp_idle_pct <= 24;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct <= 0;
               hold_start = 1'b1;
            end
         endcase
         sent = 0;
         while (sent < 320 || char_feed.size() != 0) begin
            if (char_feed.size() == 0)
               queue_phrase();
            c = char_feed.pop_front();
            send_char(c, 1'b0, fixed);
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (pending_events.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0 && pending_events.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
